/* sv/osmo_pkg.sv */
package osmo_pkg;

   // production sequencer states; rinse is a transient target only, never stored
   typedef enum logic [2:0] {
      PS_IDLE       = 3'd0,
      PS_MANUAL     = 3'd1,
      PS_PRECLEAN   = 3'd2,
      PS_CLEAN      = 3'd3,
      PS_PREOSMOSIS = 3'd4,
      PS_OSMOSIS    = 3'd5,
      PS_ERROR      = 3'd6,
      PS_RINSE      = 3'd7
   } prod_state_type;

   typedef enum logic [1:0] {
      FS_OFF    = 2'd0,
      FS_ON     = 2'd1,
      FS_ERROR  = 2'd2,
      FS_MANUAL = 2'd3
   } fill_state_type;

   // action code 3 is unused and changes nothing
   typedef enum logic [1:0] {
      ACT_TICK       = 2'd0,
      ACT_RESET_PROD = 2'd1,
      ACT_RESET_FILL = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      PEV_NONE    = 2'd0,
      PEV_STARTED = 2'd1,
      PEV_ENDED   = 2'd2
   } prod_event_type;

   typedef enum logic [1:0] {
      FEV_NONE    = 2'd0,
      FEV_STARTED = 2'd1,
      FEV_ENDED   = 2'd2,
      FEV_TIMEOUT = 2'd3
   } fill_event_type;

   typedef enum logic [2:0] {
      REG_REFILL_TIMEOUT     = 3'd0,
      REG_PRODUCTION_TIMEOUT = 3'd1,
      REG_CLEAN_DURATION     = 3'd2,
      REG_CLEAN_INTERVAL     = 3'd3,
      REG_AUTOMATIC_MODE     = 3'd4,
      REG_REFILL_ENABLE      = 3'd5
   } reg_index_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 16;

   // request tdata, lowest bit last in this list
   typedef struct packed {
      logic [2:0]  pad;
      logic        refill_manual_switch;
      logic        production_manual_switch;
      logic        aquarium_level_ok;
      logic        tank_bottom_wet;
      logic        tank_top_wet;
      logic [31:0] now_seconds;
   } req_data_type;

   typedef struct packed {
      logic [3:0]     pad;
      fill_event_type refill_event;
      prod_event_type production_event;
      logic           refill_pump;
      logic           flush_valve;
      logic           fresh_valve;
      fill_state_type refill_state;
      prod_state_type production_state;
   } rsp_data_type;

endpackage

/* sv/osmosis_plant_sequencer_core.sv */
// osmosis plant sequencer core
// one transaction on the req channel is one tick of the plant controller: tuser
// carries the action (tick, reset production machine, reset refill machine) and
// tdata the time in seconds, the level sensors and the two manual switches.
// every request gives exactly one rsp transaction with both machine states, the
// valve and pump drives and the production and refill statistics events.
// the csr port writes the timing and mode registers; write only while no
// request is in flight.
// a request taken sits in the input register, and its response is registered
// when the output is free, which raises rsp_tvalid. throughput: one request
// per clock while rsp_tready is high; the state update is a single pass of
// subtractors and 32-bit compares between the input and response registers.
// a stalled rsp_tready holds the response register; the input register still
// takes one more request, then req_tready drops until the response is taken.
// reset (synchronous) empties both registers, returns both machines to their
// idle states, clears all timers and reloads the register defaults.
module osmosis_plant_sequencer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // now_seconds[31:0], tank_top_wet, tank_bottom_wet, aquarium_level_ok,
   // production_manual_switch, refill_manual_switch, zero fill
   input  logic [osmo_pkg::REQ_DATA_W-1:0]      req_tdata,
   // action
   input  logic [1:0]                           req_tuser,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // production_state[2:0], refill_state[1:0], fresh_valve, flush_valve,
   // refill_pump, production_event[1:0], refill_event[1:0], zero fill
   output logic [osmo_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // register writes
   input  logic                                 csr_we,
   input  logic [osmo_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [osmo_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // configuration registers
   logic [15:0] refill_timeout_ff;
   logic [15:0] production_timeout_ff;
   logic [15:0] clean_duration_ff;
   logic [15:0] clean_interval_ff;
   logic        automatic_mode_ff;
   logic        refill_enable_ff;

   // input register
   logic                   s1_valid_ff;
   osmo_pkg::action_type   s1_action_ff;
   osmo_pkg::req_data_type s1_data_ff;
   logic                   s1_fire;

   // plant state
   osmo_pkg::prod_state_type prod_state_ff, prod_state_in;
   osmo_pkg::fill_state_type fill_state_ff, fill_state_in;
   logic [31:0] run_elapsed_ff,   run_elapsed_in;
   logic [31:0] run_start_ff,     run_start_in;
   logic [31:0] flush_elapsed_ff, flush_elapsed_in;
   logic [31:0] flush_start_ff,   flush_start_in;
   logic [31:0] cycle_elapsed_ff, cycle_elapsed_in;
   logic [31:0] cycle_start_ff,   cycle_start_in;
   logic [31:0] fill_elapsed_ff,  fill_elapsed_in;
   logic [31:0] fill_start_ff,    fill_start_in;
   logic        timeout_reported_ff, timeout_reported_in;

   // tick results before the action select
   osmo_pkg::prod_state_type tk_prod_state, tk_next;
   osmo_pkg::fill_state_type tk_fill_state;
   logic [31:0] tk_run_elapsed, tk_run_start, tk_flush_elapsed, tk_flush_start;
   logic [31:0] tk_cycle_elapsed, tk_cycle_start, tk_fill_elapsed, tk_fill_start;
   logic        tk_timeout_reported;
   osmo_pkg::prod_event_type tk_pev, pev_in;
   osmo_pkg::fill_event_type tk_fev, fev_in;

   logic run_over, cycle_due, flush_done, fill_over;
   logic now_top, now_bottom;
   logic [31:0] now;

   // response register
   logic                   rsp_valid_ff;
   osmo_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign now        = s1_data_ff.now_seconds;
   assign now_top    = s1_data_ff.tank_top_wet;
   assign now_bottom = s1_data_ff.tank_bottom_wet;

   assign run_over   = run_elapsed_ff >= {16'd0, production_timeout_ff};
   assign cycle_due  = cycle_elapsed_ff >= {16'd0, clean_interval_ff};
   assign flush_done = flush_elapsed_ff >= {16'd0, clean_duration_ff};
   assign fill_over  = fill_elapsed_ff >= {16'd0, refill_timeout_ff};

   // production sequencer step
   always_comb begin
      tk_prod_state    = prod_state_ff;
      tk_run_elapsed   = run_elapsed_ff;
      tk_run_start     = run_start_ff;
      tk_flush_elapsed = flush_elapsed_ff;
      tk_flush_start   = flush_start_ff;
      tk_cycle_elapsed = cycle_elapsed_ff;
      tk_cycle_start   = cycle_start_ff;
      tk_pev           = osmo_pkg::PEV_NONE;
      tk_next          = prod_state_ff;
      if (s1_data_ff.production_manual_switch) begin
         tk_prod_state = osmo_pkg::PS_MANUAL;
      end else if (prod_state_ff == osmo_pkg::PS_MANUAL) begin
         tk_prod_state = osmo_pkg::PS_IDLE;
      end else if (automatic_mode_ff) begin
         // transition priority follows the sequence order
         priority if (prod_state_ff == osmo_pkg::PS_IDLE && !now_top && !now_bottom &&
                      !run_over && !flush_done) begin
            tk_next = osmo_pkg::PS_PRECLEAN;
         end else if (prod_state_ff == osmo_pkg::PS_PRECLEAN && !now_top && !now_bottom &&
                      !run_over && !flush_done) begin
            tk_next = osmo_pkg::PS_CLEAN;
            tk_pev  = osmo_pkg::PEV_STARTED;
         end else if (prod_state_ff == osmo_pkg::PS_CLEAN && !now_top && !run_over &&
                      flush_done) begin
            tk_next = osmo_pkg::PS_PREOSMOSIS;
         end else if (prod_state_ff == osmo_pkg::PS_PREOSMOSIS && !now_top && !run_over &&
                      !cycle_due) begin
            tk_next = osmo_pkg::PS_OSMOSIS;
         end else if (prod_state_ff == osmo_pkg::PS_OSMOSIS && !now_top && !run_over &&
                      cycle_due) begin
            tk_next = osmo_pkg::PS_RINSE;
         end else if (prod_state_ff != osmo_pkg::PS_ERROR && now_top && now_bottom) begin
            if (prod_state_ff == osmo_pkg::PS_OSMOSIS) begin
               tk_pev = osmo_pkg::PEV_ENDED;
            end
            tk_next = osmo_pkg::PS_IDLE;
         end else if ((now_top && !now_bottom) || run_over) begin
            tk_next = osmo_pkg::PS_ERROR;
         end else begin
            tk_next = prod_state_ff;
         end

         // entry actions of the target state, also when staying in it
         unique case (tk_next)
            osmo_pkg::PS_IDLE: begin
               tk_flush_elapsed = '0;
               tk_run_elapsed   = '0;
               tk_cycle_elapsed = '0;
               tk_prod_state    = osmo_pkg::PS_IDLE;
            end
            osmo_pkg::PS_PRECLEAN: begin
               tk_run_start     = now;
               tk_run_elapsed   = 32'd1;
               tk_flush_elapsed = 32'd1;
               tk_flush_start   = now;
               tk_prod_state    = osmo_pkg::PS_PRECLEAN;
            end
            osmo_pkg::PS_RINSE: begin
               tk_flush_elapsed = 32'd1;
               tk_flush_start   = now;
               tk_prod_state    = osmo_pkg::PS_CLEAN;
            end
            osmo_pkg::PS_CLEAN: begin
               tk_flush_elapsed = now - flush_start_ff;
               tk_prod_state    = osmo_pkg::PS_CLEAN;
            end
            osmo_pkg::PS_PREOSMOSIS: begin
               tk_cycle_elapsed = 32'd1;
               tk_cycle_start   = now;
               tk_prod_state    = osmo_pkg::PS_PREOSMOSIS;
            end
            osmo_pkg::PS_OSMOSIS: begin
               tk_run_elapsed   = now - run_start_ff;
               tk_cycle_elapsed = now - cycle_start_ff;
               tk_prod_state    = osmo_pkg::PS_OSMOSIS;
            end
            default: begin
               tk_prod_state = osmo_pkg::PS_ERROR;
            end
         endcase
      end
   end

   // refill machine step, sees the production state of this same tick
   always_comb begin
      tk_fill_state       = fill_state_ff;
      tk_fill_elapsed     = fill_elapsed_ff;
      tk_fill_start       = fill_start_ff;
      tk_timeout_reported = timeout_reported_ff;
      tk_fev              = osmo_pkg::FEV_NONE;
      if (s1_data_ff.refill_manual_switch) begin
         tk_fill_state = osmo_pkg::FS_MANUAL;
      end else if (fill_state_ff == osmo_pkg::FS_MANUAL) begin
         tk_fill_state = osmo_pkg::FS_OFF;
      end else if (refill_enable_ff) begin
         priority if (!(automatic_mode_ff && tk_prod_state == osmo_pkg::PS_IDLE)) begin
            tk_fill_elapsed = '0;
            tk_fill_start   = '0;
            tk_fill_state   = osmo_pkg::FS_OFF;
         end else if (s1_data_ff.aquarium_level_ok && !fill_over) begin
            tk_fill_elapsed = '0;
            tk_fill_start   = '0;
            if (fill_state_ff == osmo_pkg::FS_ON) begin
               tk_fev = osmo_pkg::FEV_ENDED;
            end
            tk_fill_state = osmo_pkg::FS_OFF;
         end else if (!s1_data_ff.aquarium_level_ok && !fill_over &&
                      fill_state_ff == osmo_pkg::FS_OFF) begin
            tk_fill_elapsed = 32'd1;
            tk_fill_start   = now;
            tk_fill_state   = osmo_pkg::FS_ON;
            tk_fev          = osmo_pkg::FEV_STARTED;
         end else if (!s1_data_ff.aquarium_level_ok && !fill_over &&
                      fill_state_ff == osmo_pkg::FS_ON) begin
            tk_fill_elapsed = now - fill_start_ff;
         end else if (!s1_data_ff.aquarium_level_ok && fill_over) begin
            tk_fill_state = osmo_pkg::FS_ERROR;
            // timeout is reported once until the production machine is reset
            if (!timeout_reported_ff) begin
               tk_fev              = osmo_pkg::FEV_TIMEOUT;
               tk_timeout_reported = 1'b1;
            end
         end else if (!s1_data_ff.aquarium_level_ok &&
                      fill_state_ff != osmo_pkg::FS_ERROR) begin
            tk_fill_state = osmo_pkg::FS_OFF;
         end else begin
            tk_fill_state = osmo_pkg::FS_ERROR;
         end
      end
   end

   // action select
   always_comb begin
      prod_state_in       = prod_state_ff;
      fill_state_in       = fill_state_ff;
      run_elapsed_in      = run_elapsed_ff;
      run_start_in        = run_start_ff;
      flush_elapsed_in    = flush_elapsed_ff;
      flush_start_in      = flush_start_ff;
      cycle_elapsed_in    = cycle_elapsed_ff;
      cycle_start_in      = cycle_start_ff;
      fill_elapsed_in     = fill_elapsed_ff;
      fill_start_in       = fill_start_ff;
      timeout_reported_in = timeout_reported_ff;
      pev_in              = osmo_pkg::PEV_NONE;
      fev_in              = osmo_pkg::FEV_NONE;
      unique case (s1_action_ff)
         osmo_pkg::ACT_TICK: begin
            prod_state_in       = tk_prod_state;
            fill_state_in       = tk_fill_state;
            run_elapsed_in      = tk_run_elapsed;
            run_start_in        = tk_run_start;
            flush_elapsed_in    = tk_flush_elapsed;
            flush_start_in      = tk_flush_start;
            cycle_elapsed_in    = tk_cycle_elapsed;
            cycle_start_in      = tk_cycle_start;
            fill_elapsed_in     = tk_fill_elapsed;
            fill_start_in       = tk_fill_start;
            timeout_reported_in = tk_timeout_reported;
            pev_in              = tk_pev;
            fev_in              = tk_fev;
         end
         osmo_pkg::ACT_RESET_PROD: begin
            run_start_in        = '0;
            run_elapsed_in      = '0;
            timeout_reported_in = 1'b0;
            prod_state_in       = osmo_pkg::PS_IDLE;
         end
         osmo_pkg::ACT_RESET_FILL: begin
            fill_elapsed_in = '0;
            fill_start_in   = '0;
            fill_state_in   = osmo_pkg::FS_OFF;
         end
         default: begin
         end
      endcase
   end

   // output decode from the updated states
   always_comb begin
      rsp_data_in                  = '0;
      rsp_data_in.production_state = prod_state_in;
      rsp_data_in.refill_state     = fill_state_in;
      rsp_data_in.production_event = pev_in;
      rsp_data_in.refill_event     = fev_in;
      rsp_data_in.refill_pump      = (fill_state_in == osmo_pkg::FS_ON) ||
                                     (fill_state_in == osmo_pkg::FS_MANUAL);
      unique case (prod_state_in)
         osmo_pkg::PS_MANUAL, osmo_pkg::PS_PREOSMOSIS, osmo_pkg::PS_OSMOSIS: begin
            rsp_data_in.fresh_valve = 1'b1;
            rsp_data_in.flush_valve = 1'b0;
         end
         osmo_pkg::PS_PRECLEAN, osmo_pkg::PS_CLEAN: begin
            rsp_data_in.fresh_valve = 1'b1;
            rsp_data_in.flush_valve = 1'b1;
         end
         default: begin
            rsp_data_in.fresh_valve = 1'b0;
            rsp_data_in.flush_valve = 1'b0;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         refill_timeout_ff     <= 16'd20;
         production_timeout_ff <= 16'd9000;
         clean_duration_ff     <= 16'd10;
         clean_interval_ff     <= 16'd30;
         automatic_mode_ff     <= 1'b0;
         refill_enable_ff      <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            osmo_pkg::REG_REFILL_TIMEOUT:     refill_timeout_ff     <= csr_wdata;
            osmo_pkg::REG_PRODUCTION_TIMEOUT: production_timeout_ff <= csr_wdata;
            osmo_pkg::REG_CLEAN_DURATION:     clean_duration_ff     <= csr_wdata;
            osmo_pkg::REG_CLEAN_INTERVAL:     clean_interval_ff     <= csr_wdata;
            osmo_pkg::REG_AUTOMATIC_MODE:     automatic_mode_ff     <= csr_wdata[0];
            osmo_pkg::REG_REFILL_ENABLE:      refill_enable_ff      <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         s1_action_ff <= osmo_pkg::action_type'(req_tuser);
         s1_data_ff   <= osmo_pkg::req_data_type'(req_tdata);
      end
   end

   // plant state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_state_ff       <= osmo_pkg::PS_IDLE;
         fill_state_ff       <= osmo_pkg::FS_OFF;
         run_elapsed_ff      <= '0;
         run_start_ff        <= '0;
         flush_elapsed_ff    <= '0;
         flush_start_ff      <= '0;
         cycle_elapsed_ff    <= '0;
         cycle_start_ff      <= '0;
         fill_elapsed_ff     <= '0;
         fill_start_ff       <= '0;
         timeout_reported_ff <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (s1_fire) begin
            prod_state_ff       <= prod_state_in;
            fill_state_ff       <= fill_state_in;
            run_elapsed_ff      <= run_elapsed_in;
            run_start_ff        <= run_start_in;
            flush_elapsed_ff    <= flush_elapsed_in;
            flush_start_ff      <= flush_start_in;
            cycle_elapsed_ff    <= cycle_elapsed_in;
            cycle_start_ff      <= cycle_start_in;
            fill_elapsed_ff     <= fill_elapsed_in;
            fill_start_ff       <= fill_start_in;
            timeout_reported_ff <= timeout_reported_in;
            rsp_valid_ff        <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a processed request always leaves a response behind
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("processed request produced no response");

   // a waiting request is neither lost nor altered
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("waiting request lost or changed");

   // rinse is only a transition target
   a_no_rinse_stored: assert property (@(posedge clock) disable iff (reset)
      prod_state_ff != osmo_pkg::PS_RINSE)
      else $error("rinse code stored as production state");

   // a run start event leaves the sequencer in clean
   a_start_in_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.production_event == osmo_pkg::PEV_STARTED |->
      rsp_data_ff.production_state == osmo_pkg::PS_CLEAN)
      else $error("run start event outside clean");

   // a refill timeout event comes with the refill error state
   a_timeout_in_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.refill_event == osmo_pkg::FEV_TIMEOUT |->
      rsp_data_ff.refill_state == osmo_pkg::FS_ERROR && timeout_reported_ff)
      else $error("refill timeout event without error state");

endmodule
